[design/rip_route_table_top_macros.svh]
// Assertion macros for the route table block.
// Used by the controller and datapath files; no other dependencies.
`ifndef RIP_ROUTE_TABLE_TOP_MACROS_SVH
`define RIP_ROUTE_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RRT_ASSERT(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("route table check failed");
`define RRT_NEVER(name, ck, rs, cond) \
  name: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("route table forbidden condition");
`else
`define RRT_ASSERT(name, ck, rs, prop)
`define RRT_NEVER(name, ck, rs, cond)
`endif
`endif

[design/rrt_pkg.sv]
// Shared types and constants of the route table block.
// Used by every module of the block but rrt_ram; depends on nothing.
package rrt_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int IFACE_COUNT = 2;
  localparam int SLOT_W = 8;
  localparam int CFG_W = 16;

  localparam logic [4:0] METRIC_INF = 5'd16;
  localparam logic [15:0] ROUTE_TIMEOUT_RST = 16'd180;
  localparam logic [15:0] FLUSH_TIMEOUT_RST = 16'd120;
  localparam logic [31:0] SECONDS_RST = 32'd1;

  // Register indexes of the configuration port.
  localparam logic CFG_ROUTE_TIMEOUT = 1'b0;
  localparam logic CFG_FLUSH_TIMEOUT = 1'b1;

  // Request actions.
  localparam logic [1:0] ACT_RX = 2'd0;
  localparam logic [1:0] ACT_LOCAL = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_LOCAL = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;
  localparam logic [2:0] ST_READ = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] net_address;
    logic [31:0] rx_metric;
    logic [31:0] next_hop;
    logic        iface;
    logic [7:0]  slot_index;
    logic        final_entry;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic        entry_valid;
    logic        withdrawn;
    logic [31:0] dest_out;
    logic [31:0] hop_out;
    logic [4:0]  metric_out;
    logic        iface_out;
    logic        install_route;
    logic [8:0]  removed_count;
    logic        packet_done;
  } rsp_t;

  // One slot of the route memory; wd marks a withdrawn route.
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] hop;
    logic [4:0]  metric;
    logic [31:0] stamp;
    logic        port;
    logic        wd;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_READ, S_SCAN, S_FINISH, S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic read_issue;
    logic scan;
    logic finish;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       bad_iface;
    logic       scan_done;
    logic       out_free;
  } ctl_sts_t;

endpackage

[design/rip_route_table_top.sv]
// Top level of the RIPv1 route table block.
// Depends on rrt_pkg, rrt_ctrl, rrt_datapath and rrt_ram.
// One request is handled at a time. A read slot request reads only the slot it names;
// a received entry, a local route and a one-second tick each walk every slot of
// the route memory through its single read port. Aging writes back through the
// memory's write port during the same walk. A new request is taken while the
// previous result still waits in the output register. The user must see that
// configuration is written only while idle; the block itself does not enforce it.
module rip_route_table_top #(
  parameter int TABLE_ENTRIES = rrt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  rrt_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output rrt_pkg::rsp_t             rsp_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rrt_pkg::CFG_W-1:0] cfg_data
);

  rrt_pkg::ctl_cmd_t cmd;
  rrt_pkg::ctl_sts_t sts;

  rrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .sts(sts), .cmd(cmd)
  );

  rrt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .req_data(req_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

endmodule

[design/rrt_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rrt_ctrl.sv]
// Sequencer of the route table: walks each request through its phases.
// Depends on rrt_pkg and the assertion macro header.
`include "rip_route_table_top_macros.svh"
module rrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rrt_pkg::ctl_sts_t sts,
  output rrt_pkg::ctl_cmd_t cmd
);

  rrt_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rrt_pkg::S_IDLE: begin
        if (req_valid) state_next = rrt_pkg::S_DISPATCH;
      end
      rrt_pkg::S_DISPATCH: begin
        if (sts.act == rrt_pkg::ACT_READ) begin
          state_next = rrt_pkg::S_READ;
        end else if (sts.act != rrt_pkg::ACT_TICK && sts.bad_iface) begin
          state_next = rrt_pkg::S_FINISH;
        end else begin
          state_next = rrt_pkg::S_SCAN;
        end
      end
      rrt_pkg::S_READ: state_next = rrt_pkg::S_FINISH;
      rrt_pkg::S_SCAN: begin
        if (sts.scan_done) state_next = rrt_pkg::S_FINISH;
      end
      rrt_pkg::S_FINISH: state_next = rrt_pkg::S_EMIT;
      rrt_pkg::S_EMIT: begin
        if (sts.out_free) state_next = rrt_pkg::S_IDLE;
      end
      default: state_next = rrt_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    req_stall = (state != rrt_pkg::S_IDLE);
    cmd.start = (state == rrt_pkg::S_IDLE) && req_valid;
    cmd.read_issue = (state == rrt_pkg::S_READ);
    cmd.scan = (state == rrt_pkg::S_SCAN);
    cmd.finish = (state == rrt_pkg::S_FINISH);
    cmd.emit = (state == rrt_pkg::S_EMIT) && sts.out_free;
  end

  `RRT_ASSERT(a_start_dispatch, clk, rst, cmd.start |=> state == rrt_pkg::S_DISPATCH)

endmodule

[design/rrt_datapath.sv]
// Datapath of the route table: slot memory, flags, scan pipeline, result registers.
// Depends on rrt_pkg, rrt_ram and the assertion macro header.
`include "rip_route_table_top_macros.svh"
module rrt_datapath #(
  parameter int TABLE_ENTRIES = rrt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrt_pkg::ctl_cmd_t        cmd,
  output rrt_pkg::ctl_sts_t        sts,
  input  rrt_pkg::req_t            req_data,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [rrt_pkg::CFG_W-1:0] cfg_data,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output rrt_pkg::rsp_t            rsp_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int ENTRY_W = $bits(rrt_pkg::entry_t);

  rrt_pkg::req_t req_q;
  logic [15:0] route_timeout, flush_timeout;
  logic [31:0] seconds_now;
  logic [TABLE_ENTRIES-1:0] used_bits;
  logic [CNT_W-1:0] ptr;
  logic v1;
  logic [IDX_W-1:0] a1;
  logic found, free_found;
  logic [IDX_W-1:0] midx, fidx;
  rrt_pkg::entry_t mentry;
  logic [8:0] freed;
  rrt_pkg::rsp_t res;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  rrt_pkg::entry_t wr_data, rd_q;
  logic [ENTRY_W-1:0] rd_raw;

  rrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_raw)
  );
  assign rd_q = rd_raw;

  // Status to the sequencer.
  always_comb begin
    sts.act = req_q.action;
    sts.bad_iface = (32'(req_q.iface) >= 32'(rrt_pkg::IFACE_COUNT));
    sts.scan_done = (ptr == CNT_W'(TABLE_ENTRIES));
    sts.out_free = !rsp_valid || !rsp_stall;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_timeout <= rrt_pkg::ROUTE_TIMEOUT_RST;
      flush_timeout <= rrt_pkg::FLUSH_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == rrt_pkg::CFG_ROUTE_TIMEOUT) route_timeout <= cfg_data;
      if (cfg_index == rrt_pkg::CFG_FLUSH_TIMEOUT) flush_timeout <= cfg_data;
    end
  end

  // Seconds counter; it steps past zero so a learned stamp is never zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now <= rrt_pkg::SECONDS_RST;
    end else if (cmd.start && req_data.action == rrt_pkg::ACT_TICK) begin
      seconds_now <= (seconds_now == '1) ? 32'd1 : seconds_now + 32'd1;
    end
  end

  // Scan evaluation of the slot read in the previous cycle.
  logic scan_eval, hit, is_local, do_withdraw, do_free;
  logic [31:0] age;
  always_comb begin
    scan_eval = cmd.scan && v1;
    hit = used_bits[a1] && (rd_q.dest == req_q.net_address);
    is_local = (rd_q.stamp == 32'd0) && (rd_q.hop == 32'd0);
    age = seconds_now - rd_q.stamp;
    do_withdraw = 1'b0;
    do_free = 1'b0;
    if (scan_eval && req_q.action == rrt_pkg::ACT_TICK && used_bits[a1] && !is_local) begin
      if (!rd_q.wd) begin
        do_withdraw = (age > {16'd0, route_timeout}) || (rd_q.metric >= rrt_pkg::METRIC_INF);
      end else begin
        do_free = (age > {16'd0, flush_timeout});
      end
    end
  end

  // Final decision and write-back of a request.
  logic [4:0] sm;
  logic upd;
  rrt_pkg::entry_t new_e;
  rrt_pkg::rsp_t r;
  logic f_we, f_set_used;
  logic [IDX_W-1:0] f_addr;
  always_comb begin
    sm = (req_q.rx_metric >= 32'd15) ? rrt_pkg::METRIC_INF : 5'(req_q.rx_metric) + 5'd1;
    upd = (mentry.hop == req_q.next_hop) || ({27'd0, mentry.metric} > req_q.rx_metric);
    new_e = '0;
    r = '0;
    f_we = 1'b0;
    f_set_used = 1'b0;
    f_addr = fidx;
    unique case (req_q.action)
      rrt_pkg::ACT_RX: begin
        r.packet_done = req_q.final_entry;
        r.status = rrt_pkg::ST_IGNORED;
        if (!sts.bad_iface) begin
          if (found) begin
            r.slot = rrt_pkg::SLOT_W'(midx);
            r.entry_valid = 1'b1;
            if (upd) begin
              new_e = '{dest: mentry.dest, hop: req_q.next_hop, metric: sm,
                        stamp: seconds_now, port: req_q.iface,
                        wd: (sm < rrt_pkg::METRIC_INF) ? 1'b0 : mentry.wd};
              f_we = 1'b1;
              f_addr = midx;
              r.status = rrt_pkg::ST_UPDATED;
              r.withdrawn = new_e.wd;
              r.dest_out = new_e.dest;
              r.hop_out = new_e.hop;
              r.metric_out = new_e.metric;
              r.iface_out = new_e.port;
            end else begin
              r.withdrawn = mentry.wd;
              r.dest_out = mentry.dest;
              r.hop_out = mentry.hop;
              r.metric_out = mentry.metric;
              r.iface_out = mentry.port;
            end
          end else if (req_q.rx_metric >= 32'd16) begin
            r.status = rrt_pkg::ST_IGNORED;
          end else if (free_found) begin
            new_e = '{dest: req_q.net_address, hop: req_q.next_hop, metric: sm,
                      stamp: seconds_now, port: req_q.iface, wd: 1'b0};
            f_we = 1'b1;
            f_set_used = 1'b1;
            r.status = rrt_pkg::ST_ADDED;
            r.install_route = 1'b1;
            r.slot = rrt_pkg::SLOT_W'(fidx);
            r.entry_valid = 1'b1;
            r.dest_out = new_e.dest;
            r.hop_out = new_e.hop;
            r.metric_out = new_e.metric;
            r.iface_out = new_e.port;
          end else begin
            r.status = rrt_pkg::ST_FULL;
          end
        end
      end
      rrt_pkg::ACT_LOCAL: begin
        r.status = rrt_pkg::ST_IGNORED;
        if (!sts.bad_iface) begin
          if (free_found) begin
            new_e = '{dest: req_q.net_address, hop: 32'd0, metric: 5'd1,
                      stamp: 32'd0, port: req_q.iface, wd: 1'b0};
            f_we = 1'b1;
            f_set_used = 1'b1;
            r.status = rrt_pkg::ST_LOCAL;
            r.slot = rrt_pkg::SLOT_W'(fidx);
            r.entry_valid = 1'b1;
            r.dest_out = new_e.dest;
            r.metric_out = new_e.metric;
            r.iface_out = new_e.port;
          end else begin
            r.status = rrt_pkg::ST_FULL;
          end
        end
      end
      rrt_pkg::ACT_TICK: begin
        r.status = rrt_pkg::ST_TICK;
        r.removed_count = freed;
      end
      rrt_pkg::ACT_READ: begin
        r.status = rrt_pkg::ST_READ;
        r.slot = req_q.slot_index;
        if (32'(req_q.slot_index) < 32'(TABLE_ENTRIES) && used_bits[a1]) begin
          r.entry_valid = 1'b1;
          r.withdrawn = rd_q.wd;
          r.dest_out = rd_q.dest;
          r.hop_out = rd_q.hop;
          r.metric_out = rd_q.metric;
          r.iface_out = rd_q.port;
        end
      end
      default: r = '0;
    endcase
  end

  // Memory port selection.
  always_comb begin
    rd_addr = cmd.read_issue ? IDX_W'(req_q.slot_index) : ptr[IDX_W-1:0];
    if (cmd.finish) begin
      wr_en = f_we;
      wr_addr = f_addr;
      wr_data = new_e;
    end else begin
      wr_en = do_withdraw;
      wr_addr = a1;
      wr_data = '{dest: rd_q.dest, hop: rd_q.hop, metric: rrt_pkg::METRIC_INF,
                  stamp: seconds_now, port: rd_q.port, wd: 1'b1};
    end
  end

  // Used flag, one per slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_bits <= '0;
    end else if (cmd.finish) begin
      if (f_set_used) used_bits[f_addr] <= 1'b1;
    end else if (do_free) begin
      used_bits[a1] <= 1'b0;
    end
  end

  // Request capture, scan pointer and scan findings.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      v1 <= 1'b0;
    end else if (cmd.start) begin
      ptr <= '0;
      v1 <= 1'b0;
    end else if (cmd.scan) begin
      v1 <= !sts.scan_done;
      if (!sts.scan_done) ptr <= ptr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q <= req_data;
      found <= 1'b0;
      free_found <= 1'b0;
      freed <= '0;
    end else begin
      if (cmd.read_issue) a1 <= IDX_W'(req_q.slot_index);
      if (cmd.scan && !sts.scan_done) a1 <= ptr[IDX_W-1:0];
      if (scan_eval && hit && !found) begin
        found <= 1'b1;
        midx <= a1;
        mentry <= rd_q;
      end
      if (scan_eval && !used_bits[a1] && !free_found) begin
        free_found <= 1'b1;
        fidx <= a1;
      end
      if (do_free && freed != 9'd511) freed <= freed + 9'd1;
    end
  end

  // Result staging and output register.
  always_ff @(posedge clk) begin
    if (cmd.finish) res <= r;
    if (cmd.emit) rsp_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `RRT_NEVER(a_seconds_nonzero, clk, rst, seconds_now == 32'd0)
  `RRT_ASSERT(a_scan_write_tick, clk, rst, (cmd.scan && wr_en) |-> req_q.action == rrt_pkg::ACT_TICK)
  `RRT_ASSERT(a_rise_after_emit, clk, rst, $rose(rsp_valid) |-> $past(cmd.emit))

endmodule
